@@ hdl/windowed_jerk_estimator_top_macros.svh @@
// assertion macros for the windowed jerk estimator
// expects clk and rst_n in the scope of use
`ifndef WINDOWED_JERK_ESTIMATOR_TOP_MACROS_SVH
`define WINDOWED_JERK_ESTIMATOR_TOP_MACROS_SVH

// same-cycle implication
`define WJE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WJE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wje_pkg.sv @@
// shared types and constants for the windowed jerk estimator
// no dependencies
package wje_pkg;

    localparam int unsigned CHANNELS  = 2;
    localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = CFG_IDX_W'(1);

    localparam logic [15:0] WINDOW_TICKS_RST     = 16'd50;
    localparam logic [23:0] TICKS_PER_SECOND_RST = 24'd200000;

    localparam logic signed [31:0] JERK_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] JERK_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [0:0]         channel;
        logic signed [31:0] sample;
        logic [31:0]        timestamp;
    } wje_in_t;

    typedef struct packed {
        logic signed [31:0] jerk;
        logic               fresh;
    } wje_out_t;

    typedef struct packed {
        logic signed [31:0] prev_sample;
        logic [39:0]        diff_sum;
        logic [31:0]        window_start;
        logic signed [31:0] held_jerk;
    } wje_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_CHECK,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } wje_state_t;

endpackage

@@ hdl/windowed_jerk_estimator_top.sv @@
// windowed jerk estimator: per-channel state memory, serial multiply and divide
// depends on wje_pkg and windowed_jerk_estimator_top_macros.svh
`include "windowed_jerk_estimator_top_macros.svh"

// One sample word is taken at a time; sample_stall stays high until the result of the
// previous word has been handed to the output register. A word that only arms its channel
// or repeats the held estimate goes from CALC straight to EMIT. A word
// that closes a window goes through state memory read, difference sum, magnitude, a
// multiply split into two 20x24 partial products, an overflow check and a 32-step restoring
// divide by the elapsed tick count, one quotient bit per cycle, skipped when the estimate
// saturates. The output register lets a new word be accepted while a result waits. There is
// no clearing pass after reset: per-channel armed flags mark entries that hold no state yet.
module windowed_jerk_estimator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  wje_pkg::wje_in_t                   sample_word,
    output logic                               result_valid,
    input  logic                               result_stall,
    output wje_pkg::wje_out_t                  result_word,
    input  logic                               cfg_we,
    input  logic [wje_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wje_pkg::CFG_DATA_W-1:0]     cfg_data
);

    wje_pkg::wje_state_t             state_reg, state_next;
    logic [wje_pkg::CHANNELS-1:0]    armed_reg, armed_next;
    logic                            result_valid_reg, result_valid_next;
    wje_pkg::wje_out_t               result_word_reg, result_word_next;
    logic [15:0]                     window_ticks_reg;
    logic [23:0]                     ticks_per_second_reg;

    wje_pkg::wje_in_t                item_reg, item_next;
    wje_pkg::wje_entry_t             entry_reg, entry_next;
    wje_pkg::wje_out_t               pend_reg, pend_next;
    logic                            write_reg, write_next;
    logic [31:0]                     elapsed_reg, elapsed_next;
    logic                            neg_reg, neg_next;
    logic [39:0]                     mag_reg, mag_next;
    logic [63:0]                     prod_reg, prod_next;
    logic [31:0]                     rem_reg, rem_next;
    logic [31:0]                     lo_reg, lo_next;
    logic [31:0]                     quo_reg, quo_next;
    logic [wje_pkg::DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    wje_pkg::wje_entry_t             mem [wje_pkg::CHANNELS];
    wje_pkg::wje_entry_t             rd_data_reg;
    logic                            mem_we;

    logic                            accept;
    logic [wje_pkg::CH_W-1:0]        ch_idx;
    logic                            bad_ch;
    logic                            ch_armed;
    logic signed [31:0]              rd_held;
    logic [32:0]                     diff;
    logic [39:0]                     sum_new;
    logic [31:0]                     elapsed;
    logic [15:0]                     thr;
    logic [43:0]                     pp;
    logic [32:0]                     trial;
    logic                            ge;
    logic signed [31:0]              est;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != wje_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    assign ch_idx   = wje_pkg::CH_W'(item_reg.channel);
    assign bad_ch   = (32'(item_reg.channel) >= wje_pkg::CHANNELS);
    assign ch_armed = !bad_ch && armed_reg[ch_idx];
    assign rd_held  = ch_armed ? rd_data_reg.held_jerk : 32'sd0;

    // state memory, one entry per channel
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ch_idx] <= entry_reg;
        end
        if (accept)
        begin
            rd_data_reg <= mem[wje_pkg::CH_W'(sample_word.channel)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= wje_pkg::ST_IDLE;
            armed_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            armed_reg        <= armed_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg     <= wje_pkg::WINDOW_TICKS_RST;
            ticks_per_second_reg <= wje_pkg::TICKS_PER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wje_pkg::REG_WINDOW_TICKS:     window_ticks_reg     <= cfg_data[15:0];
                wje_pkg::REG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        result_word_reg <= result_word_next;
        item_reg        <= item_next;
        entry_reg       <= entry_next;
        pend_reg        <= pend_next;
        write_reg       <= write_next;
        elapsed_reg     <= elapsed_next;
        neg_reg         <= neg_next;
        mag_reg         <= mag_next;
        prod_reg        <= prod_next;
        rem_reg         <= rem_next;
        lo_reg          <= lo_next;
        quo_reg         <= quo_next;
        div_cnt_reg     <= div_cnt_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        armed_next        = armed_reg;
        result_valid_next = result_valid_reg;
        result_word_next  = result_word_reg;
        item_next         = item_reg;
        entry_next        = entry_reg;
        pend_next         = pend_reg;
        write_next        = write_reg;
        elapsed_next      = elapsed_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        lo_next           = lo_reg;
        quo_next          = quo_reg;
        div_cnt_next      = div_cnt_reg;
        mem_we            = 1'b0;

        diff    = {item_reg.sample[31], item_reg.sample}
                - {rd_data_reg.prev_sample[31], rd_data_reg.prev_sample};
        sum_new = rd_data_reg.diff_sum + {{7{diff[32]}}, diff};
        elapsed = item_reg.timestamp - rd_data_reg.window_start;
        thr     = (window_ticks_reg == 16'd0) ? 16'd1 : window_ticks_reg;
        pp      = '0;
        trial   = {rem_reg, lo_reg[31]};
        ge      = (trial >= {1'b0, elapsed_reg});
        est     = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            wje_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    item_next  = sample_word;
                    state_next = wje_pkg::ST_CALC;
                end
            end
            wje_pkg::ST_CALC:
            begin
                pend_next.jerk  = rd_held;
                pend_next.fresh = 1'b0;
                write_next      = 1'b0;
                state_next      = wje_pkg::ST_EMIT;
                if (bad_ch)
                begin
                    pend_next.jerk = 32'sd0;
                end
                else if (!ch_armed)
                begin
                    // first word of the channel opens the window
                    entry_next.prev_sample  = item_reg.sample;
                    entry_next.diff_sum     = '0;
                    entry_next.window_start = item_reg.timestamp;
                    entry_next.held_jerk    = rd_held;
                    write_next              = 1'b1;
                end
                else
                begin
                    entry_next.prev_sample  = item_reg.sample;
                    entry_next.diff_sum     = sum_new;
                    entry_next.window_start = rd_data_reg.window_start;
                    entry_next.held_jerk    = rd_held;
                    elapsed_next            = elapsed;
                    write_next              = 1'b1;
                    if (elapsed >= {16'd0, thr})
                    begin
                        entry_next.window_start = item_reg.timestamp;
                        state_next              = wje_pkg::ST_ABS;
                    end
                end
            end
            wje_pkg::ST_ABS:
            begin
                neg_next   = entry_reg.diff_sum[39];
                mag_next   = entry_reg.diff_sum[39] ? (40'd0 - entry_reg.diff_sum)
                                                    : entry_reg.diff_sum;
                state_next = wje_pkg::ST_MUL_LO;
            end
            wje_pkg::ST_MUL_LO:
            begin
                pp         = mag_reg[19:0] * ticks_per_second_reg;
                prod_next  = {20'd0, pp};
                state_next = wje_pkg::ST_MUL_HI;
            end
            wje_pkg::ST_MUL_HI:
            begin
                pp         = mag_reg[39:20] * ticks_per_second_reg;
                prod_next  = prod_reg + {pp, 20'd0};
                state_next = wje_pkg::ST_CHECK;
            end
            wje_pkg::ST_CHECK:
            begin
                // quotient of 2^31 or more saturates either way
                if (prod_reg >= {1'b0, elapsed_reg, 31'd0})
                begin
                    pend_next.jerk       = neg_reg ? wje_pkg::JERK_MIN : wje_pkg::JERK_MAX;
                    pend_next.fresh      = 1'b1;
                    entry_next.held_jerk = neg_reg ? wje_pkg::JERK_MIN : wje_pkg::JERK_MAX;
                    entry_next.diff_sum  = '0;
                    state_next           = wje_pkg::ST_EMIT;
                end
                else
                begin
                    rem_next     = prod_reg[63:32];
                    lo_next      = prod_reg[31:0];
                    quo_next     = '0;
                    div_cnt_next = wje_pkg::DIV_CNT_W'(wje_pkg::DIV_STEPS - 1);
                    state_next   = wje_pkg::ST_DIV;
                end
            end
            wje_pkg::ST_DIV:
            begin
                rem_next     = ge ? 32'(trial - {1'b0, elapsed_reg}) : trial[31:0];
                lo_next      = {lo_reg[30:0], 1'b0};
                quo_next     = {quo_reg[30:0], ge};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = wje_pkg::ST_FIN;
                end
            end
            wje_pkg::ST_FIN:
            begin
                pend_next.jerk       = est;
                pend_next.fresh      = 1'b1;
                entry_next.held_jerk = est;
                entry_next.diff_sum  = '0;
                state_next           = wje_pkg::ST_EMIT;
            end
            wje_pkg::ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    result_word_next  = pend_reg;
                    mem_we            = write_reg;
                    if (write_reg)
                    begin
                        armed_next[ch_idx] = 1'b1;
                    end
                    state_next = wje_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wje_pkg::ST_IDLE;
            end
        endcase
    end

    `WJE_ASSERT_NEXT(a_accept_to_calc, accept, state_reg == wje_pkg::ST_CALC, "accept did not start work")
    `WJE_ASSERT_NOW(a_rem_below_div, state_reg == wje_pkg::ST_DIV, rem_reg < elapsed_reg, "divider remainder out of range")
    `WJE_ASSERT_NEXT(a_div_ends, (state_reg == wje_pkg::ST_DIV) && (div_cnt_reg == '0), state_reg == wje_pkg::ST_FIN, "divider overran")
    `WJE_ASSERT_NEXT(a_write_with_result, mem_we, result_valid, "state written without a result")

endmodule
